FILE: rtl/pfds_pkg.sv
// Shared types, constants and helper functions for the Playfair digraph block.
`timescale 1ns / 1ps
`default_nettype none

package pfds_pkg;

    localparam int CharW  = 8;
    localparam int GridN  = 5;
    localparam int Cells  = GridN * GridN;
    localparam int PosW   = 3;
    localparam int IdxW   = 5;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 64;
    localparam int CellsPerWord = CfgDataW / CharW;
    localparam int QDepth = 4;
    localparam int QPtrW  = 2;
    localparam int QCntW  = 3;

    localparam logic [CfgIdxW-1:0] RegDecryptMode = 3'd0;
    localparam logic [CfgIdxW-1:0] RegKeyCells0   = 3'd1;
    localparam logic [CfgIdxW-1:0] RegKeyCells1   = 3'd2;
    localparam logic [CfgIdxW-1:0] RegKeyCells2   = 3'd3;
    localparam logic [CfgIdxW-1:0] RegKeyCellLast = 3'd4;

    typedef logic [Cells-1:0][CharW-1:0] t_grid;

    typedef struct packed {
        logic            hit;
        logic [PosW-1:0] row;
        logic [PosW-1:0] col;
    } t_loc;

    typedef struct packed {
        logic            miss;
        logic [PosW-1:0] row_a;
        logic [PosW-1:0] col_a;
        logic [PosW-1:0] row_b;
        logic [PosW-1:0] col_b;
    } t_pair_loc;

    function automatic logic [PosW-1:0] shift5(input logic [PosW-1:0] v, input logic back);
        logic [PosW-1:0] res;
        if (back) begin
            res = (v == '0) ? PosW'(GridN - 1) : v - 1'b1;
        end else begin
            res = (v == PosW'(GridN - 1)) ? '0 : v + 1'b1;
        end
        return res;
    endfunction

    function automatic logic [IdxW-1:0] cell_idx(input logic [PosW-1:0] row,
                                                 input logic [PosW-1:0] col);
        return IdxW'({row, 2'b00}) + IdxW'(row) + IdxW'(col);
    endfunction

    function automatic logic [CharW-1:0] upcase(input logic [CharW-1:0] ch);
        logic [CharW-1:0] res;
        res = ch;
        if (ch >= 8'h61 && ch <= 8'h7a) begin
            res = ch - 8'h20;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/pfds_front.sv
// Front end: accepts character pairs and locates both characters in the key matrix.
`timescale 1ns / 1ps
`default_nettype none

module pfds_front (
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic [pfds_pkg::CharW-1:0] i_first_char,
    input  wire logic [pfds_pkg::CharW-1:0] i_second_char,
    input  wire pfds_pkg::t_grid          i_grid,
    input  wire logic                     i_q_full,
    output logic                          o_q_push,
    output pfds_pkg::t_pair_loc           o_q_data
);

    function automatic pfds_pkg::t_loc locate(input pfds_pkg::t_grid grid,
                                             input logic [pfds_pkg::CharW-1:0] ch);
        pfds_pkg::t_loc         res;
        logic                   row_hit;
        logic [pfds_pkg::PosW-1:0] row_col;
        res = '0;
        for (int r = 0; r < pfds_pkg::GridN; r++) begin
            row_hit = 1'b0;
            row_col = '0;
            // descending scan leaves the leftmost match in the row
            for (int c = pfds_pkg::GridN - 1; c >= 0; c--) begin
                if (grid[r * pfds_pkg::GridN + c] == ch) begin
                    row_hit = 1'b1;
                    row_col = pfds_pkg::PosW'(c);
                end
            end
            // lower rows override
            if (row_hit) begin
                res.hit = 1'b1;
                res.row = pfds_pkg::PosW'(r);
                res.col = row_col;
            end
        end
        return res;
    endfunction

    pfds_pkg::t_loc loc_a;
    pfds_pkg::t_loc loc_b;

    always_comb begin
        loc_a = locate(i_grid, i_first_char);
        loc_b = locate(i_grid, i_second_char);
        o_q_data.miss  = !(loc_a.hit && loc_b.hit);
        o_q_data.row_a = loc_a.row;
        o_q_data.col_a = loc_a.col;
        o_q_data.row_b = loc_b.row;
        o_q_data.col_b = loc_b.col;
    end

    assign o_ready  = !i_q_full;
    assign o_q_push = i_valid && !i_q_full;

endmodule

`default_nettype wire

FILE: rtl/pfds_queue.sv
// Small FIFO of located pairs between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module pfds_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire pfds_pkg::t_pair_loc i_data,
    output logic                     o_full,
    input  wire logic                i_pop,
    output pfds_pkg::t_pair_loc      o_data,
    output logic                     o_empty
);

    pfds_pkg::t_pair_loc               r_mem [pfds_pkg::QDepth];
    logic [pfds_pkg::QPtrW-1:0]        r_wr_ptr;
    logic [pfds_pkg::QPtrW-1:0]        r_rd_ptr;
    logic [pfds_pkg::QCntW-1:0]        r_count;

    assign o_full  = (r_count == pfds_pkg::QCntW'(pfds_pkg::QDepth));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pfds_back.sv
// Back end: applies the Playfair rules and holds the result in an output register.
`timescale 1ns / 1ps
`default_nettype none

module pfds_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire pfds_pkg::t_grid     i_grid,
    input  wire logic                i_decrypt,
    input  wire pfds_pkg::t_pair_loc i_q_data,
    input  wire logic                i_q_empty,
    output logic                     o_q_pop,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [pfds_pkg::CharW-1:0] o_out_first,
    output logic [pfds_pkg::CharW-1:0] o_out_second,
    output logic                     o_not_in_matrix
);

    logic                        r_valid;
    logic [pfds_pkg::CharW-1:0]  r_out_first;
    logic [pfds_pkg::CharW-1:0]  r_out_second;
    logic                        r_miss;

    logic [pfds_pkg::CharW-1:0]  n_out_first;
    logic [pfds_pkg::CharW-1:0]  n_out_second;
    logic [pfds_pkg::PosW-1:0]   ra, ca, rb, cb;
    logic [pfds_pkg::IdxW-1:0]   idx_x, idx_y;

    always_comb begin
        ra = i_q_data.row_a;
        ca = i_q_data.col_a;
        rb = i_q_data.row_b;
        cb = i_q_data.col_b;
        if (ra == rb) begin
            idx_x = pfds_pkg::cell_idx(ra, pfds_pkg::shift5(ca, i_decrypt));
            idx_y = pfds_pkg::cell_idx(rb, pfds_pkg::shift5(cb, i_decrypt));
        end else if (ca == cb) begin
            idx_x = pfds_pkg::cell_idx(pfds_pkg::shift5(ra, i_decrypt), ca);
            idx_y = pfds_pkg::cell_idx(pfds_pkg::shift5(rb, i_decrypt), cb);
        end else begin
            idx_x = pfds_pkg::cell_idx(ra, cb);
            idx_y = pfds_pkg::cell_idx(rb, ca);
        end
        if (i_q_data.miss) begin
            n_out_first  = '0;
            n_out_second = '0;
        end else begin
            n_out_first  = pfds_pkg::upcase(i_grid[idx_x]);
            n_out_second = pfds_pkg::upcase(i_grid[idx_y]);
        end
    end

    assign o_q_pop = !i_q_empty && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_out_first  <= n_out_first;
            r_out_second <= n_out_second;
            r_miss       <= i_q_data.miss;
        end
    end

    assign o_valid         = r_valid;
    assign o_out_first     = r_out_first;
    assign o_out_second    = r_out_second;
    assign o_not_in_matrix = r_miss;

endmodule

`default_nettype wire

FILE: rtl/playfair_digraph_substitution_top.sv
// Top level of the Playfair digraph substitution block.
// Usage:
//   Input stream (s_axis): one character pair per transaction, tdata holds
//   first_char in [7:0] and second_char in [15:8].
//   Output stream (m_axis): one result per input transaction, tdata holds
//   out_first [7:0] and out_second [15:8]; tuser holds not_in_matrix.
//   Configuration: i_cfg_we writes register i_cfg_index with i_cfg_wdata:
//   0 decrypt mode, 1..3 matrix cells 0..23 (eight per word, low byte first),
//   4 matrix cell 24. Other indexes are ignored. Write only while idle.
//   Path: each pair is written into the queue, then into the output register
//   that drives m_axis_tvalid, which holds until m_axis_tready takes it.
//   Throughput: one pair per cycle while the receiver is ready; the front end
//   locates both characters in the same cycle the pair is taken and the back
//   end builds one result per cycle from the 4-entry queue between them.
//   When the receiver stalls the result register holds and the queue fills;
//   s_axis_tready drops only once the queue is full.
//   Reset (synchronous, active low) clears the queue, the output valid flag,
//   the decrypt mode and all matrix cells to zero; output data is not reset.
`timescale 1ns / 1ps
`default_nettype none

module playfair_digraph_substitution_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // first_char, second_char
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // out_first, out_second
    output logic             m_axis_tuser,   // not_in_matrix
    input  wire logic        i_cfg_we,
    input  wire logic [pfds_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [pfds_pkg::CfgDataW-1:0] i_cfg_wdata
);

    pfds_pkg::t_grid     r_grid;
    logic                r_decrypt;

    logic                q_push;
    logic                q_pop;
    logic                q_full;
    logic                q_empty;
    pfds_pkg::t_pair_loc q_wdata;
    pfds_pkg::t_pair_loc q_rdata;

    logic [pfds_pkg::CharW-1:0] out_first;
    logic [pfds_pkg::CharW-1:0] out_second;
    logic                       not_in_matrix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decrypt <= 1'b0;
            r_grid    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pfds_pkg::RegDecryptMode: begin
                    r_decrypt <= i_cfg_wdata[0];
                end
                pfds_pkg::RegKeyCells0: begin
                    for (int k = 0; k < pfds_pkg::CellsPerWord; k++) begin
                        r_grid[k] <= i_cfg_wdata[k*pfds_pkg::CharW +: pfds_pkg::CharW];
                    end
                end
                pfds_pkg::RegKeyCells1: begin
                    for (int k = 0; k < pfds_pkg::CellsPerWord; k++) begin
                        r_grid[pfds_pkg::CellsPerWord + k] <=
                            i_cfg_wdata[k*pfds_pkg::CharW +: pfds_pkg::CharW];
                    end
                end
                pfds_pkg::RegKeyCells2: begin
                    for (int k = 0; k < pfds_pkg::CellsPerWord; k++) begin
                        r_grid[2*pfds_pkg::CellsPerWord + k] <=
                            i_cfg_wdata[k*pfds_pkg::CharW +: pfds_pkg::CharW];
                    end
                end
                pfds_pkg::RegKeyCellLast: begin
                    r_grid[pfds_pkg::Cells-1] <= i_cfg_wdata[pfds_pkg::CharW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    pfds_front u_front (
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_first_char  (s_axis_tdata[7:0]),
        .i_second_char (s_axis_tdata[15:8]),
        .i_grid        (r_grid),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_data      (q_wdata)
    );

    pfds_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    pfds_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_grid          (r_grid),
        .i_decrypt       (r_decrypt),
        .i_q_data        (q_rdata),
        .i_q_empty       (q_empty),
        .o_q_pop         (q_pop),
        .o_valid         (m_axis_tvalid),
        .i_ready         (m_axis_tready),
        .o_out_first     (out_first),
        .o_out_second    (out_second),
        .o_not_in_matrix (not_in_matrix)
    );

    assign m_axis_tdata = {out_second, out_first};
    assign m_axis_tuser = not_in_matrix;

endmodule

`default_nettype wire
